/* src/rvx_pkg.sv */
package rvx_pkg;

  localparam int XLEN      = 32;
  localparam int REG_DEPTH = 32;
  localparam int REG_AW    = 5;

  localparam logic [6:0] OPC_OPIMM = 7'h13;
  localparam logic [6:0] OPC_LUI   = 7'h37;
  localparam logic [6:0] OPC_AUIPC = 7'h17;
  localparam logic [6:0] OPC_OP    = 7'h33;
  localparam logic [6:0] OPC_JAL   = 7'h6F;

  localparam logic [XLEN-1:0] UPPER_MASK = 32'hFFFF_F000;
  localparam logic [XLEN-1:0] PC_STEP    = 32'd4;

  typedef enum logic [2:0] {
    F3_ADD  = 3'd0,
    F3_SLL  = 3'd1,
    F3_SLT  = 3'd2,
    F3_SLTU = 3'd3,
    F3_XOR  = 3'd4,
    F3_SR   = 3'd5,
    F3_OR   = 3'd6,
    F3_AND  = 3'd7
  } funct3_t;

  typedef struct packed {
    logic              wr_en;
    logic [REG_AW-1:0] dest_index;
    logic [XLEN-1:0]   dest_value;
    logic [XLEN-1:0]   next_pc;
    logic              status;
  } result_t;

endpackage

/* src/rv32i_integer_execute.sv */
// RV32I integer execute unit.
// Input channel (in_valid/in_ready/in_instruction): one instruction word per
// transaction, executed at the current pc against the internal register file.
// Output channel (out_valid/out_ready/out_*): one result transaction per
// instruction: destination register (0 = no write), value written, next pc
// and status (1 = unimplemented opcode, treated as a no-op).
// Configuration: cfg_we/cfg_wdata load the start address into the pc; write
// it only while no transaction is in flight.
// ins_r holds an accepted transaction and out_res_r its result. Throughput:
// one transaction per cycle unless out_ready stalls; register read, ALU and
// writeback are one pass between the input and result registers, with the
// register-file read started at acceptance and same-cycle writes forwarded.
// Reset (synchronous, rst_n low): pc goes to zero, all registers read as zero,
// both pipeline registers empty.
// Output stall: a held result keeps the execute stage loaded; one further
// transaction is still accepted into it, after which in_ready drops.
module rv32i_integer_execute (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rvx_pkg::XLEN-1:0]     cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rvx_pkg::XLEN-1:0]     in_instruction,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rvx_pkg::REG_AW-1:0]   out_dest_index,
  output logic [rvx_pkg::XLEN-1:0]     out_dest_value,
  output logic [rvx_pkg::XLEN-1:0]     out_next_pc,
  output logic                        out_status
);

  logic                     ex_valid_r;
  logic                     ex_valid_nxt;
  logic [rvx_pkg::XLEN-1:0] ins_r;
  logic [rvx_pkg::XLEN-1:0] pc_r;
  logic [rvx_pkg::XLEN-1:0] pc_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  rvx_pkg::result_t         out_res_r;
  rvx_pkg::result_t         res;
  logic [rvx_pkg::XLEN-1:0] rs1_data;
  logic [rvx_pkg::XLEN-1:0] rs2_data;
  logic                     in_acc;
  logic                     ex_adv;

  assign ex_adv   = ex_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !ex_valid_r || ex_adv;
  assign in_acc   = in_valid && in_ready;

  rvx_regfile u_regfile (
    .clk(clk),
    .rst_n(rst_n),
    .rd_en(in_acc),
    .rs1_addr(in_instruction[19:15]),
    .rs2_addr(in_instruction[24:20]),
    .wr_en(ex_adv && res.wr_en),
    .wr_addr(res.dest_index),
    .wr_data(res.dest_value),
    .rs1_data(rs1_data),
    .rs2_data(rs2_data)
  );

  rvx_exec u_exec (
    .ins(ins_r),
    .pc(pc_r),
    .rs1_data(rs1_data),
    .rs2_data(rs2_data),
    .res(res)
  );

  always_comb begin
    pc_nxt = pc_r;
    if (cfg_we) begin
      pc_nxt = cfg_wdata;
    end else if (ex_adv) begin
      pc_nxt = res.next_pc;
    end
    ex_valid_nxt  = in_acc ? 1'b1 : (ex_adv ? 1'b0 : ex_valid_r);
    out_valid_nxt = ex_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
    end else begin
      ex_valid_r  <= ex_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pc_r        <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      ins_r <= in_instruction;
    end
    if (ex_adv) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_dest_index = out_res_r.dest_index;
  assign out_dest_value = out_res_r.dest_value;
  assign out_next_pc    = out_res_r.next_pc;
  assign out_status     = out_res_r.status;

  a_no_dest_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.dest_index == '0) |-> out_res_r.dest_value == '0)
    else $error("value reported without destination");

  a_unimpl_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.status |-> out_res_r.dest_index == '0)
    else $error("unimplemented opcode wrote a register");

  a_pc_follows: assert property (@(posedge clk) disable iff (!rst_n)
    ex_adv && !cfg_we |=> pc_r == out_res_r.next_pc)
    else $error("pc does not match reported next pc");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !ex_valid_r |-> in_ready)
    else $error("empty execute stage refused a transaction");

endmodule

/* src/rvx_ram.sv */
module rvx_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/rvx_regfile.sv */
module rvx_regfile (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [rvx_pkg::REG_AW-1:0] rs1_addr,
  input  logic [rvx_pkg::REG_AW-1:0] rs2_addr,
  input  logic                      wr_en,
  input  logic [rvx_pkg::REG_AW-1:0] wr_addr,
  input  logic [rvx_pkg::XLEN-1:0]   wr_data,
  output logic [rvx_pkg::XLEN-1:0]   rs1_data,
  output logic [rvx_pkg::XLEN-1:0]   rs2_data
);

  logic [rvx_pkg::REG_DEPTH-1:0] valid_r;
  logic                          vld1_r;
  logic                          vld2_r;
  logic                          byp1_r;
  logic                          byp2_r;
  logic [rvx_pkg::XLEN-1:0]      byp_data_r;
  logic [rvx_pkg::XLEN-1:0]      q1;
  logic [rvx_pkg::XLEN-1:0]      q2;

  rvx_ram #(.DATA_W(rvx_pkg::XLEN), .DEPTH(rvx_pkg::REG_DEPTH)) u_ram1 (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
    .re(rd_en), .raddr(rs1_addr), .rdata(q1)
  );

  rvx_ram #(.DATA_W(rvx_pkg::XLEN), .DEPTH(rvx_pkg::REG_DEPTH)) u_ram2 (
    .clk(clk), .we(wr_en), .waddr(wr_addr), .wdata(wr_data),
    .re(rd_en), .raddr(rs2_addr), .rdata(q2)
  );

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // write in the same cycle as the read: forward the new value
  always_ff @(posedge clk) begin
    if (rd_en) begin
      vld1_r     <= valid_r[rs1_addr];
      vld2_r     <= valid_r[rs2_addr];
      byp1_r     <= wr_en && (wr_addr == rs1_addr);
      byp2_r     <= wr_en && (wr_addr == rs2_addr);
      byp_data_r <= wr_data;
    end
  end

  assign rs1_data = byp1_r ? byp_data_r : (vld1_r ? q1 : '0);
  assign rs2_data = byp2_r ? byp_data_r : (vld2_r ? q2 : '0);

endmodule

/* src/rvx_exec.sv */
module rvx_exec (
  input  logic [rvx_pkg::XLEN-1:0] ins,
  input  logic [rvx_pkg::XLEN-1:0] pc,
  input  logic [rvx_pkg::XLEN-1:0] rs1_data,
  input  logic [rvx_pkg::XLEN-1:0] rs2_data,
  output rvx_pkg::result_t         res
);

  logic [6:0]                 op;
  logic [rvx_pkg::REG_AW-1:0] rd;
  rvx_pkg::funct3_t           f3;
  logic [rvx_pkg::XLEN-1:0]   imm_i;
  logic [rvx_pkg::XLEN-1:0]   off_j;
  logic [rvx_pkg::XLEN-1:0]   opb;
  logic [4:0]                 sh;
  logic                       alt;
  logic [rvx_pkg::XLEN-1:0]   alu_y;
  logic [rvx_pkg::XLEN-1:0]   pc_inc;
  logic [rvx_pkg::XLEN-1:0]   val;
  logic [rvx_pkg::XLEN-1:0]   next;
  logic                       writes;

  assign op     = ins[6:0];
  assign rd     = ins[11:7];
  assign f3     = rvx_pkg::funct3_t'(ins[14:12]);
  assign imm_i  = {{20{ins[31]}}, ins[31:20]};
  assign off_j  = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign pc_inc = pc + rvx_pkg::PC_STEP;
  assign opb    = (op == rvx_pkg::OPC_OP) ? rs2_data : imm_i;
  assign sh     = opb[4:0];

  always_comb begin
    if (op == rvx_pkg::OPC_OP) begin
      alt = ins[30] && ((f3 == rvx_pkg::F3_ADD) || (f3 == rvx_pkg::F3_SR));
    end else begin
      alt = ins[30] && (f3 == rvx_pkg::F3_SR);
    end
  end

  always_comb begin
    unique case (f3)
      rvx_pkg::F3_ADD:  alu_y = alt ? rs1_data - opb : rs1_data + opb;
      rvx_pkg::F3_SLL:  alu_y = rs1_data << sh;
      rvx_pkg::F3_SLT:  alu_y = {31'd0, $signed(rs1_data) < $signed(opb)};
      rvx_pkg::F3_SLTU: alu_y = {31'd0, rs1_data < opb};
      rvx_pkg::F3_XOR:  alu_y = rs1_data ^ opb;
      rvx_pkg::F3_SR:   alu_y = alt ? rvx_pkg::XLEN'($signed(rs1_data) >>> sh)
                                    : rs1_data >> sh;
      rvx_pkg::F3_OR:   alu_y = rs1_data | opb;
      rvx_pkg::F3_AND:  alu_y = rs1_data & opb;
      default:          alu_y = '0;
    endcase
  end

  always_comb begin
    val    = '0;
    next   = pc_inc;
    writes = 1'b1;
    unique case (op)
      rvx_pkg::OPC_OPIMM,
      rvx_pkg::OPC_OP:    val = alu_y;
      rvx_pkg::OPC_LUI:   val = ins & rvx_pkg::UPPER_MASK;
      rvx_pkg::OPC_AUIPC: val = (ins & rvx_pkg::UPPER_MASK) + pc;
      rvx_pkg::OPC_JAL: begin
        val  = pc_inc;
        next = pc + off_j;
      end
      default:            writes = 1'b0;
    endcase
  end

  always_comb begin
    res.next_pc = next;
    res.status  = !writes;
    res.wr_en   = writes && (rd != '0);
    res.dest_index = res.wr_en ? rd  : '0;
    res.dest_value = res.wr_en ? val : '0;
  end

endmodule

/* verif/rv32i_retire_monitor.sv */
module rv32i_retire_monitor
  import rvx_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [XLEN-1:0]   cfg_wdata,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [XLEN-1:0]   in_instruction,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [REG_AW-1:0] out_dest_index,
  input  logic [XLEN-1:0]   out_dest_value,
  input  logic [XLEN-1:0]   out_next_pc,
  input  logic              out_status,
  output int                n_faults,
  output int                n_in_flight
);

  typedef struct packed {
    logic [REG_AW-1:0] dest_index;
    logic [XLEN-1:0]   dest_value;
    logic [XLEN-1:0]   next_pc;
    logic              status;
  } retire_t;

  logic [XLEN-1:0] gpr [REG_DEPTH];
  logic [XLEN-1:0] pc;
  retire_t         retire_q [$];

  function automatic logic [XLEN-1:0] alu_op(funct3_t f3, logic alt,
                                             logic [XLEN-1:0] a, logic [XLEN-1:0] b);
    logic [4:0] sh;
    sh = b[4:0];
    case (f3)
      F3_ADD:  return alt ? a - b : a + b;
      F3_SLL:  return a << sh;
      F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
      F3_XOR:  return a ^ b;
      F3_SR: begin
        if (alt) return $signed(a) >>> sh;
        return a >> sh;
      end
      F3_OR:   return a | b;
      default: return a & b;
    endcase
  endfunction

  // Executes one instruction against the shadow register file and pc.
  function automatic retire_t predict_retire(logic [XLEN-1:0] ins);
    retire_t         r;
    logic [6:0]      op;
    funct3_t         f3;
    logic [XLEN-1:0] a, b, val, nxt;
    logic            writes;
    op     = ins[6:0];
    f3     = funct3_t'(ins[14:12]);
    a      = gpr[ins[19:15]];
    b      = gpr[ins[24:20]];
    nxt    = pc + PC_STEP;
    val    = '0;
    writes = 1'b1;
    r      = '0;
    case (op)
      OPC_OPIMM: val = alu_op(f3, f3 == F3_SR && ins[30], a, {{20{ins[31]}}, ins[31:20]});
      OPC_OP:    val = alu_op(f3, (f3 == F3_ADD || f3 == F3_SR) && ins[30], a, b);
      OPC_LUI:   val = ins & UPPER_MASK;
      OPC_AUIPC: val = (ins & UPPER_MASK) + pc;
      OPC_JAL: begin
        val = pc + PC_STEP;
        nxt = pc + {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
      end
      default: begin
        writes   = 1'b0;
        r.status = 1'b1;
      end
    endcase
    if (writes && ins[11:7] != '0) begin
      r.dest_index     = ins[11:7];
      r.dest_value     = val;
      gpr[ins[11:7]]   = val;
    end
    r.next_pc = nxt;
    pc        = nxt;
    return r;
  endfunction

  task automatic check_field(string name, logic [XLEN-1:0] want, logic [XLEN-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      n_faults++;
    end
  endtask

  always @(posedge clk) begin : watch
    retire_t want;
    if (!rst_n) begin
      foreach (gpr[i]) gpr[i] = '0;
      pc = '0;
      retire_q.delete();
      n_faults = 0;
    end else begin
      if (cfg_we) pc = cfg_wdata;
      if (in_valid && in_ready) retire_q.push_back(predict_retire(in_instruction));
      if (out_valid && out_ready) begin
        if (retire_q.size() == 0) begin
          $error("unexpected result: dest_index %0d, dest_value 0x%08h, next_pc 0x%08h",
                 out_dest_index, out_dest_value, out_next_pc);
          n_faults++;
        end else begin
          want = retire_q.pop_front();
          check_field("dest_index", 32'(want.dest_index), 32'(out_dest_index));
          check_field("dest_value", want.dest_value, out_dest_value);
          check_field("next_pc", want.next_pc, out_next_pc);
          check_field("status", 32'(want.status), 32'(out_status));
        end
      end
    end
    n_in_flight = retire_q.size();
  end

endmodule

/* verif/rv32i_integer_execute_tb.sv */
module rv32i_integer_execute_tb;
  import rvx_pkg::*;

  localparam logic [6:0] OPC_JALR = 7'h67;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [XLEN-1:0]   cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [XLEN-1:0]   in_instruction;
  logic              out_valid;
  logic              out_ready;
  logic [REG_AW-1:0] out_dest_index;
  logic [XLEN-1:0]   out_dest_value;
  logic [XLEN-1:0]   out_next_pc;
  logic              out_status;

  int n_faults;
  int n_in_flight;
  int idle_pct;
  int stall_pct;
  int n_sent;
  int n_loads;

  logic [XLEN-1:0] directed_q [$];

  always #5 clk = ~clk;

  rv32i_integer_execute u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_instruction (in_instruction),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_dest_index (out_dest_index),
    .out_dest_value (out_dest_value),
    .out_next_pc    (out_next_pc),
    .out_status     (out_status)
  );

  rv32i_retire_monitor u_mon (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_instruction (in_instruction),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_dest_index (out_dest_index),
    .out_dest_value (out_dest_value),
    .out_next_pc    (out_next_pc),
    .out_status     (out_status),
    .n_faults       (n_faults),
    .n_in_flight    (n_in_flight)
  );

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else        out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        funct3_t f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OPC_OP};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, funct3_t f3,
                                        logic [4:0] rd);
    return {imm, rs1, f3, rd, OPC_OPIMM};
  endfunction

  function automatic logic [31:0] enc_u(logic [6:0] op, logic [19:0] imm, logic [4:0] rd);
    return {imm, rd, op};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] off, logic [4:0] rd);
    return {off[20], off[10:1], off[11], off[19:12], rd, OPC_JAL};
  endfunction

  // Mostly well-formed instructions with random operands; the rest is noise.
  function automatic logic [31:0] rand_instr();
    int          pick;
    logic [4:0]  rd, rs1, rs2;
    logic [6:0]  f7;
    logic [11:0] imm;
    funct3_t     f3;
    logic [31:0] word;
    pick = $urandom_range(99);
    rd   = $urandom_range(31);
    rs1  = $urandom_range(31);
    rs2  = $urandom_range(31);
    f3   = funct3_t'($urandom_range(7));
    word = $urandom;
    case ($urandom_range(7))
      0:       imm = 12'h000;
      1:       imm = 12'h7FF;
      2:       imm = 12'h800;
      3:       imm = 12'hFFF;
      default: imm = word[31:20];
    endcase
    case ($urandom_range(4))
      0, 1:    f7 = 7'h00;
      2:       f7 = 7'h20;
      default: f7 = word[31:25];
    endcase
    if (pick < 35)      return enc_i(imm, rs1, f3, rd);
    else if (pick < 60) return enc_r(f7, rs2, rs1, f3, rd);
    else if (pick < 68) return enc_u(OPC_LUI, word[31:12], rd);
    else if (pick < 76) return enc_u(OPC_AUIPC, word[31:12], rd);
    else if (pick < 84) return enc_j(word[20:0], rd);
    else if (pick < 90) return {word[31:7], OPC_JALR};
    return word;
  endfunction

  task automatic send_instr(input logic [31:0] word);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_instruction <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_start(input logic [31:0] addr);
    cfg_we    <= 1'b1;
    cfg_wdata <= addr;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_loads++;
  endtask

  initial begin
    int              idle_tab [4];
    int              stall_tab [4];
    logic [XLEN-1:0] start_tab [4];
    idle_tab  = '{0, 73, 0, 33};
    stall_tab = '{0, 0, 73, 33};
    start_tab = '{32'hFFFF_FFFC, 32'hFFFF_FFFF, $urandom, 32'h0000_1000};
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_instruction = '0;
    idle_pct       = 0;
    stall_pct      = 0;
    n_sent         = 0;
    n_loads        = 0;

    directed_q = '{
      enc_i(12'h7FF, 5'd0, F3_ADD, 5'd1),
      enc_i(12'h800, 5'd0, F3_ADD, 5'd2),
      enc_u(OPC_LUI, 20'hFFFFF, 5'd3),
      enc_u(OPC_AUIPC, 20'hFFFFF, 5'd4),
      enc_r(7'h00, 5'd2, 5'd1, F3_ADD, 5'd5),
      enc_r(7'h20, 5'd2, 5'd1, F3_ADD, 5'd6),
      enc_r(7'h00, 5'd1, 5'd3, F3_SLL, 5'd7),
      enc_r(7'h00, 5'd1, 5'd2, F3_SLT, 5'd8),
      enc_r(7'h00, 5'd1, 5'd2, F3_SLTU, 5'd9),
      enc_r(7'h00, 5'd2, 5'd1, F3_XOR, 5'd10),
      enc_r(7'h00, 5'd1, 5'd3, F3_SR, 5'd11),
      enc_r(7'h20, 5'd1, 5'd3, F3_SR, 5'd12),
      enc_r(7'h5F, 5'd2, 5'd1, F3_OR, 5'd13),
      enc_r(7'h5F, 5'd2, 5'd3, F3_AND, 5'd14),
      enc_i({7'h7F, 5'd31}, 5'd1, F3_SLL, 5'd15),
      enc_i({7'h00, 5'd0}, 5'd3, F3_SR, 5'd16),
      enc_i({7'h20, 5'd31}, 5'd3, F3_SR, 5'd17),
      enc_i(12'h800, 5'd1, F3_SLT, 5'd18),
      enc_i(12'hFFF, 5'd1, F3_SLTU, 5'd19),
      enc_i(12'hFFF, 5'd2, F3_XOR, 5'd20),
      enc_i(12'h555, 5'd3, F3_OR, 5'd21),
      enc_i(12'hF0F, 5'd3, F3_AND, 5'd0),
      enc_j(21'h0F_FFFE, 5'd31),
      enc_j(21'h10_0000, 5'd0),
      {12'h000, 5'd1, 3'd0, 5'd2, OPC_JALR},
      32'h0000_0000,
      32'hFFFF_FFFF
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    load_start(32'h0000_0000);
    foreach (directed_q[i]) send_instr(directed_q[i]);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];
      load_start(start_tab[ph]);
      repeat (112) send_instr(rand_instr());
      drain();
    end

    $display("Executed %0d instructions (%0d directed) over four handshake pacing phases",
             n_sent, directed_q.size());
    $display("Start address loaded %0d times, from 0 up to 0xFFFFFFFF", n_loads);
    if (n_faults == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
